// ----- design/comb_filter_beat_tracker_top_macros.svh -----
// Assertion helpers for the beat tracker. Clock and reset are the block's own.
`ifndef COMB_FILTER_BEAT_TRACKER_TOP_MACROS_SVH
`define COMB_FILTER_BEAT_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CFBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfbt check failed");
`define CFBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfbt check failed");
`else
`define CFBT_ASSERT_NOW(lbl, ante, cons)
`define CFBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/cfbt_pkg.sv -----
package cfbt_pkg;

  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 8;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 19;
  localparam int WGT_W    = 17;
  localparam int STEP_W   = 5;
  localparam int MIN_PERIOD = 3;

  localparam logic [CFG_AW-1:0] REG_PERIOD_LOW  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PERIOD_HIGH = 2'd1;

  localparam logic [WGT_W-1:0]  WGT_ONE    = 17'd65536;
  localparam logic [STEP_W-1:0] WGT_STEPS  = 5'd17;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 5'd16;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- design/cfbt_ram.sv -----
module cfbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- design/cfbt_div.sv -----
// Fractional restoring divider: quo = floor(num * 2^steps / den), num < den.
module cfbt_div import cfbt_pkg::*; #(
  parameter int DW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  input  logic [DW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output div_sts_t         sts_o,
  output logic [WGT_W-1:0] quo_o
);

  logic [DW-1:0]     rem_q, den_q;
  logic [WGT_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DW:0]       dbl_c;
  logic              bit_c;
  logic [DW-1:0]     rem_d;

  always_comb begin
    dbl_c = {rem_q, 1'b0};
    bit_c = dbl_c >= {1'b0, den_q};
    rem_d = bit_c ? DW'(dbl_c - {1'b0, den_q}) : DW'(dbl_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ctl_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[WGT_W-2:0], bit_c};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

// ----- design/comb_filter_beat_tracker_top.sv -----
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+-------------------------------------------
// sample   | sample_valid_i / sample_ready_o  | sample_i
// result   | result_valid_o / result_ready_i  | found_o best_period_o best_offset_o
//          |                                  | tempo_q16_o phase_q16_o
// config   | cfg_we_i (no wait)               | cfg_addr_i cfg_wdata_i
//
// After reset the history ring is swept to zero, one entry a cycle, through all HISTORY_DEPTH
// entries; sample_ready_o stays low until the sweep ends.
// One item at a time. Each offset takes two reads of the ring's two read ports (three
// taps), each searched period a 17-step weight division (skipped where the weight is zero)
// plus a pipeline drain, and tempo and phase two 16-step divisions in the shared divider.
// A result waiting in the output register does not block the next sample transfer.
`include "comb_filter_beat_tracker_top_macros.svh"

module comb_filter_beat_tracker_top import cfbt_pkg::*; #(
  parameter int MAX_PERIOD    = 128,
  parameter int HISTORY_DEPTH = 512,
  parameter int STRIDE_STEP   = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_AW-1:0]          cfg_addr_i,
  input  logic [CFG_DW-1:0]          cfg_wdata_i,
  input  logic                       sample_valid_i,
  output logic                       sample_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       result_valid_o,
  input  logic                       result_ready_i,
  output logic                       found_o,
  output logic [7:0]                 best_period_o,
  output logic [6:0]                 best_offset_o,
  output logic [14:0]                tempo_q16_o,
  output logic [15:0]                phase_q16_o
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int PW    = $clog2(MAX_PERIOD + STRIDE_STEP + 1);
  localparam int N2W   = 2 * PW;
  localparam int PRODW = SUM_W + WGT_W + 1;

  localparam logic [AW:0] ONE_BACK     = (AW+1)'(1);
  localparam logic [AW:0] TWO_BACK     = (AW+1)'(2);
  localparam logic [AW:0] STRIDE_BACK  = (AW+1)'(STRIDE_STEP);
  localparam logic [AW:0] STRIDE2_BACK = (AW+1)'(2 * STRIDE_STEP);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_WSQ, ST_WDIV, ST_WWAIT, ST_SCAN,
    ST_DRAIN, ST_NEXT, ST_TEMPO, ST_TWAIT, ST_PWAIT, ST_DONE
  } state_e;

  // step a ring index back by k entries, wrapping at the ring depth
  function automatic logic [AW-1:0] ring_back(logic [AW-1:0] x, logic [AW:0] k);
    if ({1'b0, x} >= k) begin
      return AW'({1'b0, x} - k);
    end
    return AW'({1'b0, x} + (AW+1)'(HISTORY_DEPTH) - k);
  endfunction

  state_e             state_q;
  logic [7:0]         period_low_q, period_high_q;
  logic [AW-1:0]      clr_cnt_q, wp_q, head_q, b1_q, b2_q, a0_q, a1_q, a2_q;
  logic [PW-1:0]      lo_q, hi_q, p_q, o_q, cnt_q, best_p_q, best_o_q;
  logic [N2W-1:0]     n2_q, t2_q, div_num_q, div_den_q;
  logic [WGT_W-1:0]   w_q;
  logic               ph_q;
  logic signed [PRODW-1:0] best_q;
  div_ctl_t           div_ctl_q;
  logic [14:0]        tempo_q;
  logic [15:0]        phase_q;
  logic               res_valid_q, found_q;
  logic [7:0]         out_p_q;
  logic [6:0]         out_o_q;
  logic [14:0]        out_t_q;
  logic [15:0]        out_ph_q;

  // compare pipeline
  logic                    rd0_q, rd1_q, sum_v_q, prod_v_q;
  logic [PW-1:0]           tag_o_q, sum_o_q, prod_o_q;
  logic signed [SUM_W-1:0] part_q, sum_q;
  logic signed [PRODW-1:0] prod_q;

  div_sts_t         div_sts;
  logic [WGT_W-1:0] div_quo;

  logic [SAMPLE_W-1:0] rdata_a, rdata_b;
  logic                accept_c, pipe_busy_c;
  logic [PW-1:0]       lo_c, hi_c, start_c, n_c, dp_c, ta_c, nextp_c;
  logic signed [PW+1:0] t_c;
  logic signed [SUM_W-1:0] ea_c, eb_c;
  logic [WGT_W-1:0]    wclip_c;

  assign sample_ready_o = (state_q == ST_IDLE);
  assign accept_c       = sample_valid_i && sample_ready_o;
  assign pipe_busy_c    = rd0_q || rd1_q || sum_v_q || prod_v_q;

  always_comb begin
    lo_c    = (int'(period_low_q) > MAX_PERIOD) ? PW'(MAX_PERIOD) : PW'(period_low_q);
    hi_c    = (int'(period_high_q) > MAX_PERIOD) ? PW'(MAX_PERIOD) : PW'(period_high_q);
    start_c = (lo_c < PW'(MIN_PERIOD)) ? PW'(MIN_PERIOD) : lo_c;
    n_c     = hi_q - lo_q;
    dp_c    = p_q - lo_q;
    // t = 2(p - lo) + 1 - n, |t| < n inside the search range
    t_c     = $signed({1'b0, dp_c, 1'b1}) - $signed({2'b00, n_c});
    ta_c    = t_c[PW+1] ? PW'(-t_c) : PW'(t_c);
    nextp_c = p_q + PW'(STRIDE_STEP);
    wclip_c = (div_quo > WGT_ONE) ? WGT_ONE : div_quo;
    ea_c    = SUM_W'($signed(rdata_a));
    eb_c    = SUM_W'($signed(rdata_b));
  end

  // history ring: clearing sweep, then one write per sample transfer
  cfbt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      ((state_q == ST_CLEAR) || accept_c),
    .waddr_i   ((state_q == ST_CLEAR) ? clr_cnt_q : wp_q),
    .wdata_i   ((state_q == ST_CLEAR) ? '0 : sample_i),
    .raddr_a_i (ph_q ? a2_q : a0_q),
    .raddr_b_i (a1_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  cfbt_div #(
    .DW (N2W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_low_q  <= 8'(MIN_PERIOD);
      period_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PERIOD_LOW:  period_low_q  <= cfg_wdata_i;
        REG_PERIOD_HIGH: period_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // tap pipeline: read pair, read third tap, sum, multiply by the period weight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd0_q    <= 1'b0;
      rd1_q    <= 1'b0;
      sum_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd0_q    <= (state_q == ST_SCAN) && !ph_q;
      rd1_q    <= (state_q == ST_SCAN) && ph_q;
      sum_v_q  <= rd1_q;
      prod_v_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_o_q <= o_q;
    if (rd0_q) begin
      part_q <= (ea_c <<< 1) + ea_c + (eb_c <<< 1);
    end
    if (rd1_q) begin
      sum_q   <= part_q + ea_c;
      sum_o_q <= tag_o_q;
    end
    if (sum_v_q) begin
      prod_q   <= PRODW'(sum_q) * PRODW'($signed({1'b0, w_q}));
      prod_o_q <= sum_o_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      wp_q        <= '0;
      head_q      <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      a0_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      p_q         <= '0;
      o_q         <= '0;
      cnt_q       <= '0;
      n2_q        <= '0;
      t2_q        <= '0;
      w_q         <= '0;
      ph_q        <= 1'b0;
      best_q      <= '0;
      best_p_q    <= '0;
      best_o_q    <= '0;
      div_ctl_q   <= '0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      tempo_q     <= '0;
      phase_q     <= '0;
      res_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_p_q     <= '0;
      out_o_q     <= '0;
      out_t_q     <= '0;
      out_ph_q    <= '0;
    end else begin
      div_ctl_q.start <= 1'b0;
      if (res_valid_q && result_ready_i) begin
        res_valid_q <= 1'b0;
      end
      // keep the first strictly greater score
      if (prod_v_q && (prod_q > best_q)) begin
        best_q   <= prod_q;
        best_p_q <= p_q;
        best_o_q <= prod_o_q;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(HISTORY_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (sample_valid_i) begin
            wp_q     <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
            head_q   <= wp_q;
            b1_q     <= wp_q;
            b2_q     <= wp_q;
            lo_q     <= lo_c;
            hi_q     <= hi_c;
            p_q      <= start_c;
            cnt_q    <= start_c;
            best_q   <= '0;
            best_p_q <= '0;
            best_o_q <= '0;
            state_q  <= (start_c >= hi_c) ? ST_TEMPO : ST_INIT;
          end
        end
        ST_INIT: begin
          // walk the period taps back to the first period
          if (cnt_q == '0) begin
            state_q <= ST_WSQ;
          end else begin
            b1_q  <= ring_back(b1_q, ONE_BACK);
            b2_q  <= ring_back(b2_q, TWO_BACK);
            cnt_q <= cnt_q - PW'(1);
          end
        end
        ST_WSQ: begin
          n2_q    <= N2W'(n_c) * N2W'(n_c);
          t2_q    <= N2W'(ta_c) * N2W'(ta_c);
          state_q <= ST_WDIV;
        end
        ST_WDIV: begin
          if (t2_q >= n2_q) begin
            state_q <= ST_NEXT;
          end else begin
            div_ctl_q.start <= 1'b1;
            div_ctl_q.steps <= WGT_STEPS;
            div_num_q       <= n2_q - t2_q;
            div_den_q       <= n2_q;
            state_q         <= ST_WWAIT;
          end
        end
        ST_WWAIT: begin
          if (div_sts.done) begin
            if (wclip_c == '0) begin
              state_q <= ST_NEXT;
            end else begin
              w_q     <= wclip_c;
              a0_q    <= head_q;
              a1_q    <= b1_q;
              a2_q    <= b2_q;
              o_q     <= '0;
              ph_q    <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            a0_q <= ring_back(a0_q, ONE_BACK);
            a1_q <= ring_back(a1_q, ONE_BACK);
            a2_q <= ring_back(a2_q, ONE_BACK);
            o_q  <= o_q + PW'(1);
            if (o_q + PW'(1) == p_q) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy_c) begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          p_q     <= nextp_c;
          b1_q    <= ring_back(b1_q, STRIDE_BACK);
          b2_q    <= ring_back(b2_q, STRIDE2_BACK);
          state_q <= (nextp_c >= hi_q) ? ST_TEMPO : ST_WSQ;
        end
        ST_TEMPO: begin
          if (best_p_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            div_ctl_q.start <= 1'b1;
            div_ctl_q.steps <= FRAC_STEPS;
            div_num_q       <= N2W'(1);
            div_den_q       <= N2W'(best_p_q);
            state_q         <= ST_TWAIT;
          end
        end
        ST_TWAIT: begin
          if (div_sts.done) begin
            tempo_q         <= 15'(div_quo);
            div_ctl_q.start <= 1'b1;
            div_ctl_q.steps <= FRAC_STEPS;
            div_num_q       <= N2W'(best_o_q);
            div_den_q       <= N2W'(best_p_q);
            state_q         <= ST_PWAIT;
          end
        end
        ST_PWAIT: begin
          // hold the phase aside; the output register may still carry the last result
          if (div_sts.done) begin
            phase_q <= 16'(div_quo);
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!res_valid_q || result_ready_i) begin
            res_valid_q <= 1'b1;
            found_q     <= (best_p_q != '0);
            out_p_q     <= 8'(best_p_q);
            out_o_q     <= 7'(best_o_q);
            out_t_q     <= (best_p_q != '0) ? tempo_q : '0;
            out_ph_q    <= (best_p_q != '0) ? phase_q : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign best_period_o  = out_p_q;
  assign best_offset_o  = out_o_q;
  assign tempo_q16_o    = out_t_q;
  assign phase_q16_o    = out_ph_q;

  `CFBT_ASSERT_NOW(a_pipe_in_search, pipe_busy_c, (state_q == ST_SCAN) || (state_q == ST_DRAIN))
  `CFBT_ASSERT_NOW(a_offset_in_period, state_q == ST_SCAN, o_q < p_q)
  `CFBT_ASSERT_NEXT(a_accept_starts_work, accept_c, state_q != ST_IDLE)

endmodule

// ----- tb/comb_filter_beat_tracker_checker.sv -----
`timescale 1ns / 100ps

module comb_filter_beat_tracker_checker import cfbt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_AW-1:0]          cfg_addr_i,
  input  logic [CFG_DW-1:0]          cfg_wdata_i,
  input  logic                       sample_valid_i,
  input  logic                       sample_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       result_valid_i,
  input  logic                       result_ready_i,
  input  logic                       found_i,
  input  logic [7:0]                 best_period_i,
  input  logic [6:0]                 best_offset_i,
  input  logic [14:0]                tempo_q16_i,
  input  logic [15:0]                phase_q16_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int MaxPeriod = 128;
  localparam int Depth     = 512;
  localparam int Stride    = 1;

  typedef struct packed {
    logic        found;
    logic [7:0]  period;
    logic [6:0]  offset;
    logic [14:0] tempo;
    logic [15:0] phase;
  } beat_t;

  logic [15:0] history [Depth];
  logic [8:0]  wr_ptr;
  logic [7:0]  low_reg, high_reg;
  beat_t       expected_beats [$];

  assign pending_o = expected_beats.size();

  function automatic longint tap(int back);
    int idx;
    idx = (int'(wr_ptr) + Depth - 1 - (back % Depth)) % Depth;
    return longint'($signed(history[idx]));
  endfunction

  function automatic longint prior_weight(int p, int lo, int hi);
    longint n, t, n2, t2, w;
    n = hi - lo;
    if (n < 1) return 0;
    t  = 2 * (p - lo) + 1 - n;
    n2 = n * n;
    t2 = t * t;
    if (t2 >= n2) return 0;
    w = (131072 * (n2 - t2)) / n2;
    return (w > 65536) ? 65536 : w;
  endfunction

  // Run the full period/offset search over the current history.
  function automatic beat_t search_comb_bank();
    int     lo, hi, first;
    longint w, score, best;
    int     best_p, best_o;
    beat_t  r;
    lo = (low_reg > MaxPeriod) ? MaxPeriod : low_reg;
    hi = (high_reg > MaxPeriod) ? MaxPeriod : high_reg;
    first = (lo < MIN_PERIOD) ? MIN_PERIOD : lo;
    best = 0; best_p = 0; best_o = 0;
    for (int p = first; p < hi; p += Stride) begin
      w = prior_weight(p, lo, hi);
      for (int o = 0; o < p; o++) begin
        score = (3 * tap(o) + 2 * tap(o + p) + tap(o + 2 * p)) * w;
        if (score > best) begin
          best = score; best_p = p; best_o = o;
        end
      end
    end
    r = '0;
    if (best_p != 0) begin
      r.found  = 1'b1;
      r.period = best_p[7:0];
      r.offset = best_o[6:0];
      r.tempo  = 15'(65536 / best_p);
      r.phase  = 16'((longint'(best_o) * 65536) / best_p);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t exp_b;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) history[i] = '0;
      wr_ptr = '0;
      low_reg = 8'd3;
      high_reg = 8'd0;
      expected_beats.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_PERIOD_LOW) low_reg = cfg_wdata_i;
        else if (cfg_addr_i == REG_PERIOD_HIGH) high_reg = cfg_wdata_i;
      end
      if (sample_valid_i && sample_ready_i) begin
        history[wr_ptr] = sample_i;
        wr_ptr = wr_ptr + 9'd1;
        expected_beats.push_back(search_comb_bank());
      end
      if (result_valid_i && result_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (found_i !== exp_b.found) begin
            $error("found: expected %0d, got %0d", exp_b.found, found_i); fail_count_o++;
          end
          if (best_period_i !== exp_b.period) begin
            $error("best_period: expected %0d, got %0d", exp_b.period, best_period_i);
            fail_count_o++;
          end
          if (best_offset_i !== exp_b.offset) begin
            $error("best_offset: expected %0d, got %0d", exp_b.offset, best_offset_i);
            fail_count_o++;
          end
          if (tempo_q16_i !== exp_b.tempo) begin
            $error("tempo_q16: expected %0d, got %0d", exp_b.tempo, tempo_q16_i);
            fail_count_o++;
          end
          if (phase_q16_i !== exp_b.phase) begin
            $error("phase_q16: expected %0d, got %0d", exp_b.phase, phase_q16_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/comb_filter_beat_tracker_top_tb.sv -----
`timescale 1ns / 100ps

module comb_filter_beat_tracker_top_tb import cfbt_pkg::*; ();

  // Indexes with no register behind them; writes there must be ignored.
  localparam logic [CFG_AW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SPARE_3 = 2'd3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]          cfg_addr_i = '0;
  logic [CFG_DW-1:0]          cfg_wdata_i = '0;
  logic                       sample_valid_i = 1'b0;
  logic                       sample_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       result_valid_o;
  logic                       result_ready_i = 1'b0;
  logic                       found_o;
  logic [7:0]                 best_period_o;
  logic [6:0]                 best_offset_o;
  logic [14:0]                tempo_q16_o;
  logic [15:0]                phase_q16_o;
  int                         fail_count;
  int                         pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int pulse_count = 0;

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  comb_filter_beat_tracker_top uut (.*);

  comb_filter_beat_tracker_checker beat_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .sample_valid_i, .sample_ready_i(sample_ready_o), .sample_i,
    .result_valid_i(result_valid_o), .result_ready_i,
    .found_i(found_o), .best_period_i(best_period_o), .best_offset_i(best_offset_o),
    .tempo_q16_i(tempo_q16_o), .phase_q16_i(phase_q16_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stalls, or a long hold-off on request so the block backs up.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      result_ready_i = 1'b0;
      repeat (2000) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      result_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one sample; keep valid high across back-to-back transfers.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid_i = 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i = 1'b1;
    sample_i = value;
    @(posedge clk_i);
    while (!sample_ready_o) @(posedge clk_i);
  endtask

  // Write a register only once every expected result has drained.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    @(negedge clk_i);
    sample_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_range(int lo, int hi);
    write_reg(REG_PERIOD_LOW, lo[7:0]);
    write_reg(REG_PERIOD_HIGH, hi[7:0]);
  endtask

  // Mostly beat-like pulse trains with noise; the rest is full-range noise.
  function automatic logic signed [SAMPLE_W-1:0] onset_sample(int beat_len, bit noisy);
    logic signed [SAMPLE_W-1:0] v;
    if (noisy) begin
      v = SAMPLE_W'($urandom);
    end else if (pulse_count % beat_len == 0) begin
      v = SAMPLE_W'($urandom_range(8000, 32767));
    end else begin
      v = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    end
    pulse_count++;
    return v;
  endfunction

  initial begin
    int hi, lo, beat_len;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset range is empty: expect all zeros.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    // Full range, with extremes.
    set_range(0, 128);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    // Registers above the maximum period clamp; range becomes empty.
    set_range(255, 255);
    send_sample(16'sh7FFF);
    // Low above high.
    set_range(20, 10);
    send_sample(16'sh4000);
    // Spare indexes do nothing.
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    send_sample(16'sh7FFF);
    // Low below three, near-tie sequence of equal values.
    set_range(1, 9);
    repeat (4) send_sample(16'sh1000);
    send_sample(16'shFFFF);
    // A run of negative samples.
    set_range(3, 12);
    repeat (3) send_sample(16'sh8000);
    // Back up the block with a long receiver hold-off.
    set_range(3, 6);
    hold_req = 1'b1;
    repeat (8) send_sample(onset_sample(3, 1'b0));

    // Random part: three idling regimes.
    for (int round = 0; round < 9; round++) begin
      if (round < 3) begin
        send_idle_pct = 23; recv_idle_pct = 78;
      end else if (round < 6) begin
        send_idle_pct = 78; recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      hi = (round == 4) ? 128 : $urandom_range(4, 40);
      lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hi - 1);
      set_range(lo, hi);
      beat_len = $urandom_range(3, 12);
      repeat ((round == 4) ? 2 : 12)
        send_sample(onset_sample(beat_len, $urandom_range(0, 99) < 30));
    end

    @(negedge clk_i);
    sample_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

endmodule
